### src/rtcep_pkg.sv
// Shared types, constants and helpers for the RTC snapshot to epoch seconds converter.
package rtcep_pkg;

    localparam int unsigned DaysWidth = 17;
    localparam int unsigned SodWidth  = 20;
    localparam int unsigned EpochWidth = 32;
    localparam int unsigned CfgIndexWidth = 2;

    localparam logic [DaysWidth-1:0]  Days1970To2000 = 17'd10957;
    localparam logic [DaysWidth-1:0]  SecsPerDay     = 17'd86400;
    // Smallest day count: year 00, January, day 0.
    localparam logic [DaysWidth-1:0]  DaysMin        = 17'd10956;
    // Largest seconds-of-day: 255 s + 255 min + 255 h, all undecoded binary.
    localparam logic [SodWidth-1:0]   SodMax         = 20'd933555;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_DATA_IS_BINARY = 2'd0,
        CFG_HOURS_ARE_24   = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] seconds;
        logic [7:0] minutes;
        logic [7:0] hours;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
    } raw_fields_t;

    typedef struct packed {
        logic [DaysWidth-1:0] days;
        logic [SodWidth-1:0]  sod;
    } calc_t;

    // Packed BCD byte to binary; bad nibbles are decoded arithmetically.
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
        logic [7:0] tens;
        tens = {4'd0, v[7:4]};
        return (tens << 3) + (tens << 1) + {4'd0, v[3:0]};
    endfunction

    // Days in the year before the first of a month, month index 0 is January.
    function automatic logic [8:0] days_before_month(input logic [3:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

### src/rtcep_calc.sv
// Field decode, day count and seconds-of-day for one captured snapshot.
module rtcep_calc
    import rtcep_pkg::*;
(
    input  raw_fields_t raw,
    input  logic        data_is_binary,
    input  logic        hours_are_24,
    output calc_t       calc
);

    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic [7:0] hour12;
    logic [7:0] day;
    logic [7:0] month_dec;
    logic [3:0] month;
    logic [7:0] yy;
    logic [8:0] yy_plus3;
    logic [DaysWidth-1:0] year_days;
    logic       leap_adj;

    function automatic logic [7:0] dec(input logic [7:0] v, input logic bin);
        return bin ? v : bcd_to_bin(v);
    endfunction

    always_comb
    begin
        sec       = dec(raw.seconds, data_is_binary);
        min       = dec(raw.minutes, data_is_binary);
        day       = dec(raw.day, data_is_binary);
        month_dec = dec(raw.month, data_is_binary);
        yy        = dec(raw.year, data_is_binary);

        // 12-hour mode: strip PM, 12 counts as 0, then PM adds 12.
        hour12 = dec({1'b0, raw.hours[6:0]}, data_is_binary);
        if (hour12 == 8'd12)
        begin
            hour12 = 8'd0;
        end
        if (raw.hours[7])
        begin
            hour12 = hour12 + 8'd12;
        end
        hour = hours_are_24 ? dec(raw.hours, data_is_binary) : hour12;

        if (month_dec == 8'd0)
        begin
            month = 4'd1;
        end
        else if (month_dec > 8'd12)
        begin
            month = 4'd12;
        end
        else
        begin
            month = month_dec[3:0];
        end

        yy_plus3  = {1'b0, yy} + 9'd3;
        year_days = DaysWidth'({9'd0, yy} * 17'd365);
        leap_adj  = (yy[1:0] == 2'd0) && (month > 4'd2);

        calc.days = Days1970To2000 + year_days
                  + {10'd0, yy_plus3[8:2]}
                  + {8'd0, days_before_month(month - 4'd1)}
                  + {16'd0, leap_adj}
                  + {9'd0, day}
                  - 17'd1;

        calc.sod = {12'd0, sec}
                 + SodWidth'({12'd0, min} * 20'd60)
                 + SodWidth'({12'd0, hour} * 20'd3600);
    end

endmodule

### src/rtc_fields_to_epoch_seconds.sv
// Top level: RTC register snapshot to 32-bit Unix seconds, three register stages.
//
//  channel | signals                                  | handshake
//  --------+------------------------------------------+-------------------------------
//  command | start, busy, raw_seconds .. raw_year     | taken when start && !busy
//  result  | done, epoch_seconds                      | done high one cycle, no stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data| written when valid && ready
//
// One snapshot per cycle; busy never rises. Each snapshot passes through the
// input register, the decode/day-count register, then the days * 86400
// multiply into the result register. Reset clears the stage valids and loads
// the register defaults (BCD, 24-hour). The receiver cannot stall the pipeline.
module rtc_fields_to_epoch_seconds
    import rtcep_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [7:0]               raw_seconds,
    input  logic [7:0]               raw_minutes,
    input  logic [7:0]               raw_hours,
    input  logic [7:0]               raw_day,
    input  logic [7:0]               raw_month,
    input  logic [7:0]               raw_year,
    output logic                     done,
    output logic [EpochWidth-1:0]    epoch_seconds,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic                     cfg_data
);

    logic        data_is_binary_reg;
    logic        hours_are_24_reg;
    logic        in_valid_reg;
    raw_fields_t raw_reg;
    raw_fields_t raw_next;
    logic        mid_valid_reg;
    calc_t       calc_reg;
    calc_t       calc_next;
    logic        done_reg;
    logic [EpochWidth-1:0] epoch_reg;
    logic [EpochWidth-1:0] epoch_next;
    logic [2*DaysWidth-1:0] day_secs;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    assign raw_next = '{seconds: raw_seconds, minutes: raw_minutes, hours: raw_hours,
                        day: raw_day, month: raw_month, year: raw_year};

    rtcep_calc u_calc
    (
        .raw            (raw_reg),
        .data_is_binary (data_is_binary_reg),
        .hours_are_24   (hours_are_24_reg),
        .calc           (calc_next)
    );

    assign day_secs   = calc_reg.days * SecsPerDay;
    assign epoch_next = day_secs[EpochWidth-1:0] + {12'd0, calc_reg.sod};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_is_binary_reg <= 1'b0;
            hours_are_24_reg   <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DATA_IS_BINARY: data_is_binary_reg <= cfg_data;
                CFG_HOURS_ARE_24:   hours_are_24_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start && !busy;
            mid_valid_reg <= in_valid_reg;
            done_reg      <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            raw_reg <= raw_next;
        end
        if (in_valid_reg)
        begin
            calc_reg <= calc_next;
        end
        if (mid_valid_reg)
        begin
            epoch_reg <= epoch_next;
        end
    end

    assign done          = done_reg;
    assign epoch_seconds = epoch_reg;

`ifndef SYNTH
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##2 done)
        else $error("accepted transaction did not produce a result");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_valid_reg, 2))
        else $error("result strobe without an accepted transaction");

    a_days_floor: assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid_reg |-> (calc_reg.days >= DaysMin))
        else $error("day count below 2000-01-00");

    a_sod_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid_reg |-> (calc_reg.sod <= SodMax))
        else $error("seconds-of-day out of range");
`endif

endmodule
